>>> design/phdl_pkg.sv
// Shared types and constants for the perfect hash displacement lookup.
package phdl_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned CELLS           = 33;   // one dividend bit per cell
    localparam int unsigned S_TDATA_W       = 112;
    localparam int unsigned M_TDATA_W       = 48;

    typedef enum logic [1:0] {
        CFG_KEY_COUNT     = 2'd0,
        CFG_BUCKET_COUNT  = 2'd1,
        CFG_DENSE_SPLIT   = 2'd2,
        CFG_DENSE_BUCKETS = 2'd3
    } t_cfg_idx;

    // Word moving along the cell chain: two remainder lanes plus carried fields.
    typedef struct packed {
        logic        vld;
        logic        wr;
        logic [9:0]  idx;
        logic [31:0] val;
        logic [31:0] keep;
        logic [31:0] r2;
        logic [32:0] da;
        logic [32:0] db;
        logic [31:0] ra;
        logic [31:0] rb;
    } t_word;

    // Result of the bucket map and table read stage.
    typedef struct packed {
        logic        vld;
        logic        bad;
        logic [10:0] bucket;
        logic [31:0] r2;
        logic [31:0] disp;
    } t_look;

endpackage

>>> design/perfect_hash_displacement_lookup.sv
// Top level of the perfect hash displacement lookup.
//
// Takes one word per cycle (lookup or table write) unless the pipeline holds,
// and returns one word per lookup, in order. A lookup passes three chains of
// 33 remainder cells (hash reduction by key_count, bucket reduction by
// dense_buckets and bucket_count, final reduction of displacement plus
// offset), one bit per cell, with the table read stage between the second and
// third chain and an output register after the third. Table
// writes travel the first two chains and take effect in the table stage, so
// they are ordered with lookups. A skid register beside the output register
// catches the word leaving the last cell when the sink stalls; the pipeline
// holds only while that skid register is full, so s_axis_tready does not
// depend on m_axis_tready in the same cycle. A lookup of a table entry never
// written returns an undefined position.
module perfect_hash_displacement_lookup #(
    parameter int unsigned TABLE_DEPTH = phdl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  phdl_pkg::t_cfg_idx              i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_hash[31:0], second_hash[63:32], entry_index[73:64], entry_value[105:74]
    input  logic [phdl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                            s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // position[31:0], bucket[42:32]
    output logic [phdl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // bad_bucket[0]
    output logic                            m_axis_tuser
);
    import phdl_pkg::*;

    // configuration
    logic [31:0] r_key_count;
    logic [10:0] r_bucket_count;
    logic [31:0] r_dense_split;
    logic [10:0] r_dense_buckets;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count     <= 32'd1;
            r_bucket_count  <= 11'd1;
            r_dense_split   <= 32'd0;
            r_dense_buckets <= 11'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_COUNT:     r_key_count     <= i_cfg_data;
                CFG_BUCKET_COUNT:  r_bucket_count  <= i_cfg_data[10:0];
                CFG_DENSE_SPLIT:   r_dense_split   <= i_cfg_data;
                CFG_DENSE_BUCKETS: r_dense_buckets <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // a zero modulus reduces to zero, same as modulus one
    logic [31:0] kdiv, bcdiv, dbdiv;
    assign kdiv  = (r_key_count == 32'd0) ? 32'd1 : r_key_count;
    assign bcdiv = (r_bucket_count == 11'd0) ? 32'd1 : {21'd0, r_bucket_count};
    assign dbdiv = (r_dense_buckets == 11'd0) ? 32'd1 : {21'd0, r_dense_buckets};

    // global advance: hold everything only while the skid register is full
    logic  r_out_vld;
    logic  r_skid_vld;
    logic  en;
    logic  out_free;
    assign en            = !r_skid_vld;
    assign s_axis_tready = en;
    assign out_free      = !r_out_vld || m_axis_tready;

    // chain A: both hashes mod key_count
    t_word w_a [CELLS+1];
    always_comb begin
        w_a[0]      = '0;
        w_a[0].vld  = s_axis_tvalid;
        w_a[0].wr   = s_axis_tuser;
        w_a[0].idx  = s_axis_tdata[73:64];
        w_a[0].val  = s_axis_tdata[105:74];
        w_a[0].da   = {1'b0, s_axis_tdata[31:0]};
        w_a[0].db   = {1'b0, s_axis_tdata[63:32]};
    end

    // chain B: reduced first hash mod dense_buckets and mod bucket_count
    t_word w_b [CELLS+1];
    always_comb begin
        w_b[0]      = w_a[CELLS];
        w_b[0].keep = w_a[CELLS].ra;
        w_b[0].r2   = w_a[CELLS].rb;
        w_b[0].da   = {1'b0, w_a[CELLS].ra};
        w_b[0].db   = {1'b0, w_a[CELLS].ra};
        w_b[0].ra   = 32'd0;
        w_b[0].rb   = 32'd0;
    end

    // chain C: (displacement + offset) mod key_count
    t_look look;
    t_word w_c [CELLS+1];
    always_comb begin
        w_c[0]      = '0;
        w_c[0].vld  = look.vld;
        w_c[0].keep = {20'd0, look.bad, look.bucket};
        w_c[0].da   = look.bad ? 33'd0 : ({1'b0, look.disp} + {1'b0, look.r2});
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_cells
        phdl_cell u_cell_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w_a[g]),
            .i_div_a (kdiv),
            .i_div_b (kdiv),
            .o_word  (w_a[g+1])
        );
        phdl_cell u_cell_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w_b[g]),
            .i_div_a (dbdiv),
            .i_div_b (bcdiv),
            .o_word  (w_b[g+1])
        );
        phdl_cell u_cell_c (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w_c[g]),
            .i_div_a (kdiv),
            .i_div_b (kdiv),
            .o_word  (w_c[g+1])
        );
    end

    phdl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_word          (w_b[CELLS]),
        .i_bucket_count  (r_bucket_count),
        .i_dense_split   (r_dense_split),
        .i_dense_buckets (r_dense_buckets),
        .o_look          (look)
    );

    // output register plus skid register
    logic        take;
    logic [31:0] r_pos;
    logic [10:0] r_bucket;
    logic        r_bad;
    logic [31:0] r_skid_pos;
    logic [10:0] r_skid_bucket;
    logic        r_skid_bad;

    // a lookup result leaves the last cell this cycle
    assign take = en && w_c[CELLS].vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= take;
            end
        end else if (take) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_pos    <= r_skid_pos;
                r_bucket <= r_skid_bucket;
                r_bad    <= r_skid_bad;
            end else begin
                r_pos    <= w_c[CELLS].ra;
                r_bucket <= w_c[CELLS].keep[10:0];
                r_bad    <= w_c[CELLS].keep[11];
            end
        end
        if (!out_free && take) begin
            r_skid_pos    <= w_c[CELLS].ra;
            r_skid_bucket <= w_c[CELLS].keep[10:0];
            r_skid_bad    <= w_c[CELLS].keep[11];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_bucket, r_pos};
    assign m_axis_tuser  = r_bad;
endmodule

>>> design/phdl_cell.sv
// One restoring-remainder cell: a single dividend bit on each of two lanes.
module phdl_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  phdl_pkg::t_word       i_word,
    input  logic [31:0]           i_div_a,
    input  logic [31:0]           i_div_b,
    output phdl_pkg::t_word       o_word
);
    import phdl_pkg::*;

    t_word       r_word;
    t_word       n_word;
    logic [32:0] ta;
    logic [32:0] tb;

    always_comb begin
        n_word = i_word;
        ta = {i_word.ra, i_word.da[32]};
        tb = {i_word.rb, i_word.db[32]};
        if (ta >= {1'b0, i_div_a}) begin
            ta = ta - {1'b0, i_div_a};
        end
        if (tb >= {1'b0, i_div_b}) begin
            tb = tb - {1'b0, i_div_b};
        end
        n_word.ra = ta[31:0];
        n_word.rb = tb[31:0];
        n_word.da = {i_word.da[31:0], 1'b0};
        n_word.db = {i_word.db[31:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
endmodule

>>> design/phdl_table.sv
// Bucket mapping, displacement memory write and registered read.
module phdl_table #(
    parameter int unsigned TABLE_DEPTH = phdl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  phdl_pkg::t_word       i_word,
    input  logic [10:0]           i_bucket_count,
    input  logic [31:0]           i_dense_split,
    input  logic [10:0]           i_dense_buckets,
    output phdl_pkg::t_look       o_look
);
    import phdl_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [31:0] mem [TABLE_DEPTH];

    logic [11:0]   bucket;
    logic          bad;
    logic          hit;
    logic [31:0]   idx_w;
    logic [31:0]   bkt_w;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic          r_vld;
    logic          r_bad;
    logic          r_hit;
    logic [10:0]   r_bucket;
    logic [31:0]   r_r2;
    logic [31:0]   r_disp;

    always_comb begin
        if (i_word.keep < i_dense_split) begin
            bucket = {1'b0, i_word.ra[10:0]};
        end else if (i_word.rb[10:0] < i_dense_buckets) begin
            bucket = {1'b0, i_word.rb[10:0]} + {1'b0, i_dense_buckets};
        end else begin
            bucket = {1'b0, i_word.rb[10:0]};
        end
        bad     = bucket >= {1'b0, i_bucket_count};
        bkt_w   = {20'd0, bucket};
        idx_w   = {22'd0, i_word.idx};
        hit     = !bad && (bkt_w < 32'(TABLE_DEPTH));
        wr_addr = idx_w[AW-1:0];
        rd_addr = bkt_w[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_word.vld && i_word.wr && (idx_w < 32'(TABLE_DEPTH))) begin
                mem[wr_addr] <= i_word.val;
            end
            r_disp   <= mem[rd_addr];
            r_bad    <= bad;
            r_hit    <= hit;
            r_bucket <= bucket[10:0];
            r_r2     <= i_word.r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_word.vld && !i_word.wr;
        end
    end

    always_comb begin
        o_look.vld    = r_vld;
        o_look.bad    = r_bad;
        o_look.bucket = r_bucket;
        o_look.r2     = r_r2;
        o_look.disp   = r_hit ? r_disp : 32'd0;
    end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the perfect hash displacement lookup: directed and random words.

class hash_slot_board;
    logic [31:0] key_count, bucket_count, dense_split, dense_buckets;
    logic [31:0] disp_table [1024];
    logic [31:0] want_pos[$];
    logic [10:0] want_bucket[$];
    logic        want_bad[$];
    int          mismatches;

    function new();
        key_count = 1; bucket_count = 1; dense_split = 0; dense_buckets = 1;
        mismatches = 0;
        foreach (disp_table[i]) disp_table[i] = 0;
    endfunction

    function void set_reg(phdl_pkg::t_cfg_idx idx, logic [31:0] value);
        case (idx)
            phdl_pkg::CFG_KEY_COUNT:     key_count = value;
            phdl_pkg::CFG_BUCKET_COUNT:  bucket_count = value & 32'h7ff;
            phdl_pkg::CFG_DENSE_SPLIT:   dense_split = value;
            phdl_pkg::CFG_DENSE_BUCKETS: dense_buckets = value & 32'h7ff;
            default: ;
        endcase
    endfunction

    function logic [31:0] rem(logic [31:0] x, logic [31:0] d);
        return (d == 0) ? 32'd0 : x % d;
    endfunction

    // bucket a first hash maps to, as the full index
    function logic [31:0] bucket_of(logic [31:0] h1);
        logic [31:0] red, r;
        red = rem(h1, key_count);
        if (red < dense_split) return rem(red, dense_buckets);
        r = rem(red, bucket_count);
        if (r < dense_buckets) r = r + dense_buckets;
        return r;
    endfunction

    function void note_word(logic wr, logic [31:0] h1, logic [31:0] h2,
                            logic [9:0] idx, logic [31:0] val);
        logic [31:0] b, d;
        logic [63:0] sum;
        logic        bad;
        if (wr) begin
            disp_table[idx] = val;
            return;
        end
        b = bucket_of(h1);
        bad = (b >= bucket_count);
        want_bad.push_back(bad);
        want_bucket.push_back(b[10:0]);
        if (bad) begin
            want_pos.push_back(32'd0);
        end else begin
            d = (b < 1024) ? disp_table[b[9:0]] : 32'd0;
            sum = {32'd0, d} + {32'd0, rem(h2, key_count)};
            want_pos.push_back((key_count == 0) ? 32'd0 : 32'(sum % {32'd0, key_count}));
        end
    endfunction

    function void check_word(logic [31:0] pos, logic [10:0] bkt, logic bad);
        logic [31:0] ep;
        logic [10:0] eb;
        logic        ebad;
        if (want_pos.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word pos=%h", pos);
            return;
        end
        ep = want_pos.pop_front(); eb = want_bucket.pop_front(); ebad = want_bad.pop_front();
        if (pos !== ep || bkt !== eb || bad !== ebad) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp pos=%h bucket=%0d bad=%b, got pos=%h bucket=%0d bad=%b",
                         ep, eb, ebad, pos, bkt, bad);
        end
    endfunction

    function int pending();
        return want_pos.size();
    endfunction
endclass

module testbench;
    import phdl_pkg::*;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index = CFG_KEY_COUNT;
    logic [31:0]          i_cfg_data = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = 0;
    logic                 s_axis_tuser = 0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    hash_slot_board board;
    int  cycles = 0;
    bit  sink_quiet = 0;     // when set the sink never stalls
    int  stall_left = 0;
    // entries written so far; lookups land only on these, on bad buckets or beyond the table
    bit  written [1024];

    always #6 i_clk = ~i_clk;

    perfect_hash_displacement_lookup i_dut (.*);

    // timeout guard: ~1000 words with long gaps and stalls fit well below this
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("perfect_hash_displacement_lookup verification failed");
            $finish;
        end
    end

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata[31:0], m_axis_tdata[42:32], m_axis_tuser);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 0;
            end else if (!sink_quiet && $urandom_range(0, 99) < 20) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(0, 3);
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    function int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    endfunction

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, value);
    endtask

    task automatic send_word(logic wr, logic [31:0] h1, logic [31:0] h2,
                             logic [9:0] idx, logic [31:0] val, bit gaps);
        int gap;
        s_axis_tvalid <= 1;
        s_axis_tuser  <= wr;
        s_axis_tdata  <= {6'd0, val, idx, h2, h1};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_word(wr, h1, h2, idx, val);
        if (wr) written[idx] = 1;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = gap_len();
            if (gap > 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // lookup whose bucket is a written entry, or a bad bucket
    task automatic send_lookup(logic [31:0] h1, logic [31:0] h2, bit gaps);
        logic [31:0] b;
        int tries;
        tries = 0;
        b = board.bucket_of(h1);
        while (b < board.bucket_count && b < 1024 && !written[b[9:0]] && tries < 50) begin
            h1 = $urandom(); tries++;
            b = board.bucket_of(h1);
        end
        if (b < board.bucket_count && b < 1024 && !written[b[9:0]])
            send_word(1, 0, 0, b[9:0], $urandom(), gaps);
        send_word(0, h1, h2, 0, 0, gaps);
    endtask

    // drain the pipeline before touching registers
    task automatic settle();
        s_axis_tvalid <= 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [31:0] kc, logic [31:0] bc, logic [31:0] ds,
                                 logic [31:0] db);
        settle();
        write_reg(CFG_KEY_COUNT, kc);
        write_reg(CFG_BUCKET_COUNT, bc);
        write_reg(CFG_DENSE_SPLIT, ds);
        write_reg(CFG_DENSE_BUCKETS, db);
        i_cfg_valid <= 0;
    endtask

    initial begin
        logic [31:0] kc;
        logic [31:0] bc, db;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extreme displacements, the rest of the table is filled on demand
        apply_setting(32'hffff_ffff, 1024, 32'h8000_0000, 1024);
        send_word(1, 0, 0, 0, 32'hffff_ffff, 0);
        send_word(1, 0, 0, 10'h3ff, 32'h0000_0000, 0);
        send_word(1, 32'hffff_ffff, 32'hffff_ffff, 10'h155, 32'hffff_fffe, 0);
        send_word(1, 0, 0, 10'h2aa, 32'h5555_5555, 0);
        // extremes of the hashes, dense and sparse groups, large displacement
        send_lookup(32'h0, 32'h0, 0);
        send_lookup(32'hffff_ffff, 32'hffff_ffff, 0);
        send_lookup(32'hffff_fffe, 32'hffff_fffe, 0);
        send_lookup(32'h7fff_ffff, 32'h8000_0000, 0);
        send_lookup(32'haaaa_aaaa, 32'h5555_5555, 0);
        // zero moduli and a wide bucket beyond both the count and the table
        apply_setting(0, 0, 0, 0);
        send_lookup(32'h1234_5678, 32'h9abc_def0, 0);
        apply_setting(5000, 2047, 0, 2047);
        send_lookup(32'd4000, 32'd77, 0);
        send_lookup(32'd100, 32'd77, 0);
        apply_setting(5000, 2047, 0, 1500);
        send_lookup(32'd1800, 32'd7, 0);  // bucket 1800: valid, beyond table
        send_lookup(32'd200, 32'd7, 0);   // bucket 1700: valid, beyond table
        apply_setting(1, 1, 32'hffff_ffff, 1);
        send_lookup(32'hffff_ffff, 32'hffff_ffff, 0);

        // random phases with changing settings
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0: kc = $urandom_range(1, 64);
                1: kc = $urandom_range(1, 5000);
                2: kc = 32'hffff_ffff - $urandom_range(0, 3);
                default: kc = $urandom();
            endcase
            bc = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(1, 1100);
            db = $urandom_range(1, bc);
            apply_setting(kc, bc,
                          ($urandom_range(0, 1) != 0) ? 32'($urandom() % (64'(kc) + 64'd1))
                                                      : $urandom(), db);
            sink_quiet = (ph % 4 == 3);
            for (int n = 0; n < 90; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(1, $urandom(), $urandom(), 10'($urandom_range(0, 1023)),
                              ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom(), 1);
                else
                    send_lookup($urandom(), $urandom(), ph % 4 != 2);
            end
        end

        settle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("perfect_hash_displacement_lookup verification clean");
        else
            $display("perfect_hash_displacement_lookup verification failed");
        $finish;
    end
endmodule

>>> perfect_hash_displacement_lookup.f
design/phdl_pkg.sv
design/phdl_cell.sv
design/phdl_table.sv
design/perfect_hash_displacement_lookup.sv
bench/testbench.sv
